>>> rtl/art_pkg.sv
package art_pkg;

	// Field widths fixed by the transaction format
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned REGION_W = 17;
	localparam int unsigned CLASS_W  = 3;
	localparam int unsigned TID_W    = 32;
	localparam int unsigned BYTES_W  = 5;
	localparam int unsigned GEN_W    = 5;
	localparam int unsigned OUT_W    = 3;

	// Base word index (byte_offset / 4) and the word index after adding a segment step
	localparam int unsigned BASE_W = OFFSET_W - 2;
	localparam int unsigned WORD_W = BASE_W + 1;

	// Segment counts up to eight
	localparam int unsigned SEG_W = 4;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_KERNEL = 1'b1;

	localparam logic [CLASS_W-1:0] CLS_LOAD         = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_STORE        = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_ATOMIC_RMW   = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_PREFETCH     = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_ATOMIC_STORE = 3'd4;
	localparam logic [CLASS_W-1:0] CLS_OTHER        = 3'd5;

	localparam logic [OUT_W-1:0] OC_NO_HISTORY     = 3'd0;
	localparam logic [OUT_W-1:0] OC_OTHER_THREAD   = 3'd1;
	localparam logic [OUT_W-1:0] OC_NOT_REDUNDANT  = 3'd2;
	localparam logic [OUT_W-1:0] OC_DEAD_STORE     = 3'd3;
	localparam logic [OUT_W-1:0] OC_DEAD_LOAD      = 3'd4;
	localparam logic [OUT_W-1:0] OC_OTHER_EQUAL    = 3'd5;
	localparam logic [OUT_W-1:0] OC_LOAD_AFTER_ST  = 3'd6;

	localparam logic [REGION_W-1:0] REGION_RESET = 17'h10000;

	typedef struct packed {
		logic               is_kernel;
		logic [BASE_W-1:0]  word;
		logic [CLASS_W-1:0] cls;
		logic [TID_W-1:0]   tid;
		logic [SEG_W-1:0]   nseg;
	} cmd_t;

	// Shadow table record
	typedef struct packed {
		logic               valid;
		logic [GEN_W-1:0]   gen;
		logic [CLASS_W-1:0] cls;
		logic [TID_W-1:0]   tid;
	} rec_t;

endpackage

>>> rtl/art_front.sv
module art_front #(
	parameter int unsigned MAX_SEGMENTS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic [art_pkg::OFFSET_W-1:0]  byte_offset,
	input  logic [art_pkg::CLASS_W-1:0]   access_class,
	input  logic [art_pkg::TID_W-1:0]     thread_id,
	input  logic [art_pkg::BYTES_W-1:0]   access_bytes,
	input  logic                          region_we,
	input  logic [art_pkg::REGION_W-1:0]  region_wdata,
	input  logic                          q_full,
	input  logic                          clearing,
	output logic                          q_push,
	output art_pkg::cmd_t                 q_cmd
);
	import art_pkg::*;

	logic [REGION_W-1:0]  region_q;
	logic [BYTES_W:0]     bsum;
	logic [SEG_W-1:0]     segs_raw;
	logic [SEG_W-1:0]     segs;
	logic                 in_region;
	logic [REGION_W-1:0]  rem;
	logic [REGION_W:0]    rsum;
	logic [REGION_W-2:0]  room;
	logic [SEG_W-1:0]     nseg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_RESET;
		end else if (region_we) begin
			region_q <= region_wdata;
		end
	end

	// segments started by the size, capped
	assign bsum     = (BYTES_W+1)'(access_bytes) + (BYTES_W+1)'(3);
	assign segs_raw = bsum[BYTES_W:2];
	assign segs     = (segs_raw > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : segs_raw;

	// segments that still start inside the region
	assign in_region = REGION_W'(byte_offset) < region_q;
	assign rem       = region_q - REGION_W'(byte_offset);
	assign rsum      = (REGION_W+1)'(rem) + (REGION_W+1)'(3);
	assign room      = rsum[REGION_W:2];

	always_comb begin
		if (!in_region) begin
			nseg = '0;
		end else if (room < (REGION_W-1)'(segs)) begin
			nseg = room[SEG_W-1:0];
		end else begin
			nseg = segs;
		end
	end

	assign full = q_full || clearing;

	// accesses with no segment are taken and dropped
	assign q_push = push && !full && ((kind == KIND_KERNEL) || (nseg != '0));

	assign q_cmd.is_kernel = kind;
	assign q_cmd.word      = byte_offset[OFFSET_W-1:2];
	assign q_cmd.cls       = access_class;
	assign q_cmd.tid       = thread_id;
	assign q_cmd.nseg      = nseg;

endmodule

>>> rtl/art_cmd_queue.sv
module art_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  art_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          valid,
	output art_pkg::cmd_t head,
	input  logic          pop
);
	import art_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/art_back.sv
module art_back #(
	parameter int unsigned SHADOW_WORDS = 16384
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  art_pkg::cmd_t              q_head,
	output logic                       q_pop,
	output logic                       clearing,
	output logic                       empty,
	input  logic                       pop,
	output logic [art_pkg::OUT_W-1:0]  outcome,
	output logic                       redundant,
	output logic                       last_segment
);
	import art_pkg::*;

	localparam int unsigned IDX_W = $clog2(SHADOW_WORDS);
	localparam int unsigned EXT_W = (IDX_W > WORD_W) ? IDX_W : WORD_W;

	function automatic logic [OUT_W-1:0] judge(rec_t old, logic [GEN_W-1:0] gen,
			logic [CLASS_W-1:0] cls, logic [TID_W-1:0] tid);
		logic old_writes;
		logic cur_reads;
		old_writes = old.cls inside {CLS_STORE, CLS_ATOMIC_RMW, CLS_ATOMIC_STORE};
		cur_reads  = cls inside {CLS_LOAD, CLS_ATOMIC_RMW};
		if (!old.valid || old.gen != gen) begin
			return OC_NO_HISTORY;
		end
		if (old.tid != tid) begin
			return OC_OTHER_THREAD;
		end
		if (old.cls == cls) begin
			if (cls inside {CLS_STORE, CLS_ATOMIC_STORE}) begin
				return OC_DEAD_STORE;
			end
			if (cls == CLS_LOAD) begin
				return OC_DEAD_LOAD;
			end
			return OC_OTHER_EQUAL;
		end
		if (old_writes && cur_reads) begin
			return OC_LOAD_AFTER_ST;
		end
		return OC_NOT_REDUNDANT;
	endfunction

	rec_t               mem [SHADOW_WORDS];
	rec_t               rdata_q;

	logic [GEN_W-1:0]   gen_q;
	logic               clr_busy_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [SEG_W-1:0]   seg_k_q;

	logic               s1_valid_q;
	logic [IDX_W-1:0]   idx_s1;
	logic [GEN_W-1:0]   gen_s1;
	logic [CLASS_W-1:0] cls_s1;
	logic [TID_W-1:0]   tid_s1;
	logic               last_s1;
	logic               fwd_s1;
	rec_t               fwd_rec_s1;

	logic               out_valid_q;
	logic [OUT_W-1:0]   outcome_q;
	logic               last_q;

	logic               pop_ok;
	logic               s1_adv;
	logic               s1_free;
	logic               issue;
	logic               kstep;
	logic               seg_last;
	logic [WORD_W-1:0]  word;
	logic [EXT_W-1:0]   word_ext;
	logic [IDX_W-1:0]   issue_idx;
	logic [GEN_W-1:0]   gen_next;
	rec_t               fresh_s1;
	rec_t               old_rec;
	logic [OUT_W-1:0]   oc;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	rec_t               mem_wd;

	assign pop_ok   = pop && out_valid_q;
	assign s1_adv   = s1_valid_q && (!out_valid_q || pop_ok);
	assign s1_free  = !s1_valid_q || s1_adv;
	assign issue    = !clr_busy_q && q_valid && !q_head.is_kernel && s1_free;
	// a kernel start waits for the segment in flight so that it judges
	// and writes under the old generation
	assign kstep    = !clr_busy_q && q_valid && q_head.is_kernel && !s1_valid_q;
	assign seg_last = (seg_k_q + SEG_W'(1)) == q_head.nseg;
	assign q_pop    = kstep || (issue && seg_last);
	assign gen_next = gen_q + GEN_W'(1);

	// index wraps modulo the table depth
	assign word      = WORD_W'(q_head.word) + WORD_W'(seg_k_q);
	assign word_ext  = EXT_W'(word);
	assign issue_idx = word_ext[IDX_W-1:0];

	assign fresh_s1 = '{valid: 1'b1, gen: gen_s1, cls: cls_s1, tid: tid_s1};
	assign old_rec  = fwd_s1 ? fwd_rec_s1 : rdata_q;
	assign oc       = judge(old_rec, gen_s1, cls_s1, tid_s1);

	assign mem_we = clr_busy_q || s1_adv;
	assign mem_wa = clr_busy_q ? clr_idx_q : idx_s1;
	assign mem_wd = clr_busy_q ? rec_t'('0) : fresh_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rdata_q <= mem[issue_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= '0;
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			seg_k_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(SHADOW_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end else if (kstep) begin
				gen_q <= gen_next;
				if (gen_next == '0) begin
					clr_busy_q <= 1'b1;
					clr_idx_q  <= '0;
				end
			end

			if (issue) begin
				seg_k_q <= seg_last ? '0 : seg_k_q + SEG_W'(1);
			end

			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (pop_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= issue_idx;
			gen_s1  <= gen_q;
			cls_s1  <= q_head.cls;
			tid_s1  <= q_head.tid;
			last_s1 <= seg_last;
			// the memory returns the old word when the read meets this write
			fwd_s1     <= s1_adv && (idx_s1 == issue_idx);
			fwd_rec_s1 <= fresh_s1;
		end
		if (s1_adv) begin
			outcome_q <= oc;
			last_q    <= last_s1;
		end
	end

	assign clearing     = clr_busy_q;
	assign empty        = !out_valid_q;
	assign outcome      = outcome_q;
	assign redundant    = outcome_q >= OC_DEAD_STORE;
	assign last_segment = last_q;

endmodule

>>> rtl/access_redundancy_tracker_unit.sv
// Channel  | Handshake             | Carries
// ---------+-----------------------+---------------------------------------------
// input    | push / full           | kind, byte_offset, access_class, thread_id,
//          |                       | access_bytes
// result   | empty / pop           | outcome, redundant, last_segment
// config   | region_we             | region_wdata (region size in bytes)
//
// One shadow read-modify-write per segment: the back end walks an access
// segment by segment, and a new segment can issue as the one before it moves on.
// A kernel start is taken once the segment in flight has retired.
// After reset, and whenever the generation wraps to zero, a clearing pass
// writes every shadow word with full held high.
// Up to four transactions wait in the command queue; a stalled result holds
// the back end only, the front keeps accepting until the queue fills.
module access_redundancy_tracker_unit #(
	parameter int unsigned SHADOW_WORDS = 16384, // power of two
	parameter int unsigned MAX_SEGMENTS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic [art_pkg::OFFSET_W-1:0]  byte_offset,
	input  logic [art_pkg::CLASS_W-1:0]   access_class,
	input  logic [art_pkg::TID_W-1:0]     thread_id,
	input  logic [art_pkg::BYTES_W-1:0]   access_bytes,
	output logic                          empty,
	input  logic                          pop,
	output logic [art_pkg::OUT_W-1:0]     outcome,
	output logic                          redundant,
	output logic                          last_segment,
	input  logic                          region_we,
	input  logic [art_pkg::REGION_W-1:0]  region_wdata
);
	import art_pkg::*;

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_valid;
	cmd_t q_head;
	logic q_pop;
	logic clearing;

	// front: region register, segment count, drop of empty accesses
	art_front #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.byte_offset  (byte_offset),
		.access_class (access_class),
		.thread_id    (thread_id),
		.access_bytes (access_bytes),
		.region_we    (region_we),
		.region_wdata (region_wdata),
		.q_full       (q_full),
		.clearing     (clearing),
		.q_push       (q_push),
		.q_cmd        (q_cmd)
	);

	art_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head),
		.pop      (q_pop)
	);

	// back: generation, shadow table walk, result register
	art_back #(
		.SHADOW_WORDS(SHADOW_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.empty        (empty),
		.pop          (pop),
		.outcome      (outcome),
		.redundant    (redundant),
		.last_segment (last_segment)
	);

endmodule

>>> rtl/art_checker.sv
module art_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic [art_pkg::OUT_W-1:0]     outcome,
	input logic                          redundant,
	input logic                          last_segment
);
	import art_pkg::*;

	// a waiting result is held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(outcome) && $stable(last_segment))
		else $error("result changed while waiting");

	a_redundant: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> redundant == (outcome == OC_DEAD_STORE || outcome == OC_DEAD_LOAD
			|| outcome == OC_OTHER_EQUAL || outcome == OC_LOAD_AFTER_ST))
		else $error("redundant flag disagrees with outcome");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> outcome <= OC_LOAD_AFTER_ST)
		else $error("outcome code out of range");

	// clearing pass starts straight out of reset
	a_reset_clear: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> full && empty)
		else $error("block not in clearing pass after reset");

endmodule

bind access_redundancy_tracker_unit art_checker u_art_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.outcome      (outcome),
	.redundant    (redundant),
	.last_segment (last_segment)
);

>>> tb/access_redundancy_tracker_unit_tb.sv
module access_redundancy_tracker_unit_tb;

	import art_pkg::*;

	localparam int unsigned SHADOW_WORDS   = 16384;
	localparam int unsigned MAX_SEGMENTS   = 4;
	// Quiet cycles allowed: a full clearing pass plus generous margin
	localparam int unsigned WATCHDOG_LIMIT = 4 * SHADOW_WORDS;
	// Enough for four queued transactions of four segments each to retire
	localparam int unsigned SETTLE_CYCLES  = 32;

	// Unlisted class codes
	localparam logic [CLASS_W-1:0] CLS_SPARE_LO = 3'd6;
	localparam logic [CLASS_W-1:0] CLS_SPARE_HI = 3'd7;

	// One input transaction as the sender sees it
	typedef struct {
		logic               kind;
		logic [OFFSET_W-1:0] offset;
		logic [CLASS_W-1:0]  cls;
		logic [TID_W-1:0]    tid;
		logic [BYTES_W-1:0]  nbytes;
	} access_t;

	// One per-segment result
	typedef struct packed {
		logic [OUT_W-1:0] outcome;
		logic             redundant;
		logic             last_seg;
	} segment_verdict_t;

	// Shadow-table predictor plus the in-order store of verdicts still owed by the DUT.
	class redundancy_scoreboard;
		rec_t                shadow[SHADOW_WORDS];
		logic [GEN_W-1:0]    generation;
		logic [REGION_W-1:0] region;
		segment_verdict_t    pending_verdicts[$];
		int unsigned         errors;

		function new();
			clear_table();
			generation = '0;
			region     = REGION_RESET;
			errors     = 0;
		endfunction

		function void clear_table();
			foreach (shadow[i])
				shadow[i] = '0;
		endfunction

		function bit is_read_class(logic [CLASS_W-1:0] c);
			return c == CLS_LOAD || c == CLS_ATOMIC_RMW;
		endfunction

		function bit is_write_class(logic [CLASS_W-1:0] c);
			return c == CLS_STORE || c == CLS_ATOMIC_RMW || c == CLS_ATOMIC_STORE;
		endfunction

		function logic [OUT_W-1:0] classify(rec_t old, logic [CLASS_W-1:0] cls,
			logic [TID_W-1:0] tid);
			if (!old.valid || old.gen != generation)
				return OC_NO_HISTORY;
			if (old.tid != tid)
				return OC_OTHER_THREAD;
			if (old.cls == cls) begin
				if (cls == CLS_STORE || cls == CLS_ATOMIC_STORE)
					return OC_DEAD_STORE;
				if (cls == CLS_LOAD)
					return OC_DEAD_LOAD;
				return OC_OTHER_EQUAL;
			end
			if (is_write_class(old.cls) && is_read_class(cls))
				return OC_LOAD_AFTER_ST;
			return OC_NOT_REDUNDANT;
		endfunction

		// Apply one accepted transaction and queue the verdicts it owes
		function void note_access(access_t a);
			int unsigned      segs;
			int unsigned      n;
			int unsigned      addr;
			int unsigned      idx;
			rec_t             fresh;
			segment_verdict_t v;
			if (a.kind == KIND_KERNEL) begin
				generation++;
				if (generation == '0)
					clear_table();
				return;
			end
			segs = (a.nbytes + 3) / 4;
			if (segs > MAX_SEGMENTS)
				segs = MAX_SEGMENTS;
			n = 0;
			while (n < segs && a.offset + 4 * n < region)
				n++;
			fresh.valid = 1'b1;
			fresh.gen   = generation;
			fresh.cls   = a.cls;
			fresh.tid   = a.tid;
			for (int unsigned k = 0; k < n; k++) begin
				addr = a.offset + 4 * k;
				idx  = (addr >> 2) % SHADOW_WORDS;
				v.outcome   = classify(shadow[idx], a.cls, a.tid);
				v.redundant = v.outcome >= OC_DEAD_STORE;
				v.last_seg  = k + 1 == n;
				shadow[idx] = fresh;
				pending_verdicts.insert(pending_verdicts.size(), v);
			end
		endfunction

		function void check_verdict(logic [OUT_W-1:0] oc, logic red, logic last_seg);
			segment_verdict_t want;
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: outcome %0d redundant %0d last_segment %0d",
					oc, red, last_seg);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (oc !== want.outcome) begin
				$error("outcome: expected %0d, got %0d", want.outcome, oc);
				errors++;
			end
			if (red !== want.redundant) begin
				$error("redundant: expected %0d, got %0d", want.redundant, red);
				errors++;
			end
			if (last_seg !== want.last_seg) begin
				$error("last_segment: expected %0d, got %0d", want.last_seg, last_seg);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                push;
	logic                full;
	logic                kind;
	logic [OFFSET_W-1:0] byte_offset;
	logic [CLASS_W-1:0]  access_class;
	logic [TID_W-1:0]    thread_id;
	logic [BYTES_W-1:0]  access_bytes;
	logic                empty;
	logic                pop;
	logic [OUT_W-1:0]    outcome;
	logic                redundant;
	logic                last_segment;
	logic                region_we;
	logic [REGION_W-1:0] region_wdata;

	redundancy_scoreboard tracker_sb = new();

	// Small pool of thread ids so that same-thread histories actually build up
	logic [TID_W-1:0] tid_pool[4];

	// Burst modes: while set, that side neither idles nor stalls
	bit send_quiet = 1'b0;
	bit pop_quiet  = 1'b0;

	int unsigned quiet_cycles = 0;

	access_redundancy_tracker_unit #(
		.SHADOW_WORDS(SHADOW_WORDS),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.byte_offset (byte_offset),
		.access_class(access_class),
		.thread_id   (thread_id),
		.access_bytes(access_bytes),
		.empty       (empty),
		.pop         (pop),
		.outcome     (outcome),
		.redundant   (redundant),
		.last_segment(last_segment),
		.region_we   (region_we),
		.region_wdata(region_wdata)
	);

	always #1 clk = ~clk;

	// Watchdog: counts cycles in which neither side completes a transaction
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Drive one transaction after a random gap and hold it until accepted.
	// push is left high on return; the next call either keeps it high with new
	// data or lowers it for its gap, so push sees one assignment per step.
	task automatic send_access(input access_t a);
		int unsigned gap;
		gap = send_quiet ? 0 : $urandom_range(0, 8);
		if ($urandom_range(0, 29) == 0)
			send_quiet = !send_quiet;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		kind         <= a.kind;
		byte_offset  <= a.offset;
		access_class <= a.cls;
		thread_id    <= a.tid;
		access_bytes <= a.nbytes;
		do
			@(posedge clk);
		while (full);
		tracker_sb.note_access(a);
	endtask

	function automatic access_t make_access(logic [OFFSET_W-1:0] off, logic [CLASS_W-1:0] cls,
		logic [TID_W-1:0] tid, logic [BYTES_W-1:0] nbytes);
		access_t a;
		a.kind   = KIND_ACCESS;
		a.offset = off;
		a.cls    = cls;
		a.tid    = tid;
		a.nbytes = nbytes;
		return a;
	endfunction

	// Kernel start with junk in the ignored fields
	function automatic access_t kernel_start();
		access_t a;
		a.kind   = KIND_KERNEL;
		a.offset = OFFSET_W'($urandom);
		a.cls    = CLASS_W'($urandom);
		a.tid    = $urandom;
		a.nbytes = BYTES_W'($urandom);
		return a;
	endfunction

	// Mostly a narrow window of addresses and pooled threads, so that entries
	// get revisited; some traffic at the region boundary and the top of the
	// offset range, some fully random.
	function automatic access_t random_access();
		access_t     a;
		int unsigned pick;
		int unsigned lim;
		if ($urandom_range(0, 15) == 0)
			return kernel_start();
		a.kind = KIND_ACCESS;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			a.offset = OFFSET_W'($urandom_range(0, 127));
		end else if (pick < 75) begin
			lim = (tracker_sb.region > REGION_RESET) ? REGION_RESET : tracker_sb.region;
			a.offset = OFFSET_W'((lim > 64) ? lim - $urandom_range(1, 64)
				: $urandom_range(0, 63));
		end else if (pick < 90) begin
			a.offset = OFFSET_W'(32'h0000FF80 + $urandom_range(0, 127));
		end else begin
			a.offset = OFFSET_W'($urandom);
		end
		a.cls = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom_range(6, 7))
			: CLASS_W'($urandom_range(0, 5));
		a.tid = ($urandom_range(0, 4) == 0) ? $urandom : tid_pool[$urandom_range(0, 3)];
		pick = $urandom_range(0, 99);
		if (pick < 85)
			a.nbytes = BYTES_W'($urandom_range(1, 16));
		else if (pick < 95)
			a.nbytes = BYTES_W'($urandom_range(17, 31));
		else
			a.nbytes = '0;
		return a;
	endfunction

	// Hold off the sender until every owed verdict is in, then let the back end
	// drain anything that owes none (kernel starts, zero-length accesses,
	// a clearing pass with full held high).
	task automatic settle();
		push <= 1'b0;
		while (tracker_sb.pending_verdicts.size() != 0)
			@(posedge clk);
		do
			repeat (SETTLE_CYCLES) @(posedge clk);
		while (full);
	endtask

	task automatic write_region(input logic [REGION_W-1:0] value);
		region_we    <= 1'b1;
		region_wdata <= value;
		@(posedge clk);
		region_we <= 1'b0;
		tracker_sb.region = value;
	endtask

	// Walks a chain of class pairings on one word, then other-thread, zero and
	// oversized lengths, the region boundary and a generation change.
	task automatic run_directed();
		logic [TID_W-1:0] ta;
		logic [TID_W-1:0] tb;
		ta = '0;
		tb = '1;
		send_access(make_access(16'h0000, CLS_LOAD, ta, 5'd1));
		send_access(make_access(16'h0000, CLS_LOAD, ta, 5'd1));
		send_access(make_access(16'h0000, CLS_STORE, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_STORE, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_LOAD, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_ATOMIC_RMW, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_ATOMIC_RMW, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_LOAD, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_ATOMIC_STORE, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_ATOMIC_STORE, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_ATOMIC_RMW, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_PREFETCH, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_PREFETCH, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_OTHER, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_OTHER, ta, 5'd4));
		// unlisted class codes behave as neither read nor write
		send_access(make_access(16'h0000, CLS_SPARE_HI, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_SPARE_HI, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_SPARE_LO, ta, 5'd4));
		send_access(make_access(16'h0000, CLS_LOAD, tb, 5'd4));
		send_access(make_access(16'h0000, CLS_STORE, tb, 5'd0));
		// oversized length saturates at four segments, top of the table
		send_access(make_access(16'hFFF0, CLS_STORE, tb, 5'd31));
		// last byte of the region: walk stops after the first segment
		send_access(make_access(16'hFFFF, CLS_STORE, tb, 5'd16));
		send_access(kernel_start());
		send_access(make_access(16'h0000, CLS_LOAD, tb, 5'd4));
		send_access(make_access(16'h0002, CLS_LOAD, tb, 5'd5));
	endtask

	task automatic run_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			send_access(random_access());
			// occasional full drain mid-phase
			if ($urandom_range(0, 39) == 0)
				settle();
		end
	endtask

	// Result side: random stalls, then pop until a result is taken
	initial begin
		int unsigned stall;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pop_quiet ? 0 : $urandom_range(0, 8);
			if ($urandom_range(0, 29) == 0)
				pop_quiet = !pop_quiet;
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			tracker_sb.check_verdict(outcome, redundant, last_segment);
		end
	end

	initial begin
		logic [REGION_W-1:0] region_plan[5];
		int unsigned         item_plan[5];
		arst_n       = 1'b0;
		push         = 1'b0;
		kind         = KIND_ACCESS;
		byte_offset  = '0;
		access_class = CLS_LOAD;
		thread_id    = '0;
		access_bytes = '0;
		region_we    = 1'b0;
		region_wdata = '0;
		foreach (tid_pool[i])
			tid_pool[i] = $urandom;
		// one pair differing only in the lane bits
		tid_pool[1] = {tid_pool[0][TID_W-1:5], ~tid_pool[0][4:0]};
		// 1-byte region, empty region, past the table end (index wrap), random, reset size
		region_plan = '{17'd1, 17'd0, 17'h1FFFF, 17'($urandom_range(2, 65535)), REGION_RESET};
		item_plan   = '{30, 20, 150, 150, 150};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_region(REGION_RESET);
		run_directed();
		settle();

		foreach (region_plan[p]) begin
			write_region(region_plan[p]);
			// last phase: run the generation round to zero so the table clears
			if (p == 4) begin
				do
					send_access(kernel_start());
				while (tracker_sb.generation != '0);
			end
			// top word of the offset range; with the wide region it crosses the table end
			send_access(make_access(16'hFFFC, CLASS_W'($urandom_range(0, 5)), tid_pool[0],
				5'd16));
			run_random(item_plan[p]);
			settle();
		end

		if (tracker_sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/art_pkg.sv
rtl/art_front.sv
rtl/art_cmd_queue.sv
rtl/art_back.sv
rtl/access_redundancy_tracker_unit.sv
rtl/art_checker.sv
tb/access_redundancy_tracker_unit_tb.sv
